>>> hdl/qrs_pkg.sv
// shared types and codes of the quadratic root solver
`default_nettype none
package qrs_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CPLX  = 2'd1;
  localparam logic [1:0] ST_NOSOL = 2'd2;

  typedef enum logic [1:0] {
    K_ROOTS,
    K_CPLX,
    K_ZERO,
    K_NOSOL
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  lin;
    logic  neg_m;
    logic  neg_p;
  } ctl_t;

endpackage
`default_nettype wire

>>> hdl/qrs_sqrt_cell.sv
// one digit step of the integer square root chain
`default_nettype none
module qrs_sqrt_cell #(
  parameter int DW   = 32,
  parameter int RW   = 33,
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire qrs_pkg::ctl_t   ctl_in,
  input  wire logic [2*RW-1:0] d_in,
  input  wire logic [RW:0]     rem_in,
  input  wire logic [RW-1:0]   root_in,
  input  wire logic [DW-1:0]   a_in,
  input  wire logic [DW-1:0]   b_in,
  input  wire logic [DW-1:0]   c_in,
  output logic                 v_out,
  output qrs_pkg::ctl_t        ctl_out,
  output logic [2*RW-1:0]      d_out,
  output logic [RW:0]          rem_out,
  output logic [RW-1:0]        root_out,
  output logic [DW-1:0]        a_out,
  output logic [DW-1:0]        b_out,
  output logic [DW-1:0]        c_out
);
  import qrs_pkg::*;

  logic [RW+2:0] sh;
  logic [RW+2:0] trial;
  logic          take;
  logic          v_r;
  ctl_t          ctl_r;
  logic [2*RW-1:0] d_r;
  logic [RW:0]   rem_r;
  logic [RW+2:0] rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [DW-1:0] a_r, b_r, c_r;

  always_comb begin
    sh    = {rem_in, d_in[2*RW-1-2*STEP -: 2]};
    trial = {1'b0, root_in, 2'b01};
    take  = (sh >= trial);
    rem_nxt  = take ? (sh - trial) : sh;
    root_nxt = {root_in[RW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) begin
      ctl_r  <= ctl_in;
      d_r    <= d_in;
      rem_r  <= rem_nxt[RW:0];
      root_r <= root_nxt;
      a_r    <= a_in;
      b_r    <= b_in;
      c_r    <= c_in;
    end
  end

  assign v_out    = v_r;
  assign ctl_out  = ctl_r;
  assign d_out    = d_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign a_out    = a_r;
  assign b_out    = b_r;
  assign c_out    = c_r;
endmodule
`default_nettype wire

>>> hdl/qrs_div_cell.sv
// one quotient bit of the twin restoring divider chain
`default_nettype none
module qrs_div_cell #(
  parameter int DW = 32,
  parameter int XW = 50
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          v_in,
  input  wire qrs_pkg::ctl_t ctl_in,
  input  wire logic [DW:0]   den_in,
  input  wire logic [XW-1:0] xm_in,
  input  wire logic [XW-1:0] xp_in,
  input  wire logic [DW:0]   remm_in,
  input  wire logic [DW:0]   remp_in,
  input  wire logic [XW-1:0] qm_in,
  input  wire logic [XW-1:0] qp_in,
  output logic               v_out,
  output qrs_pkg::ctl_t      ctl_out,
  output logic [DW:0]        den_out,
  output logic [XW-1:0]      xm_out,
  output logic [XW-1:0]      xp_out,
  output logic [DW:0]        remm_out,
  output logic [DW:0]        remp_out,
  output logic [XW-1:0]      qm_out,
  output logic [XW-1:0]      qp_out
);
  import qrs_pkg::*;

  logic [DW+1:0] shm, shp, dd;
  logic          tm, tp;
  logic [DW+1:0] rm_nxt, rp_nxt;
  logic          v_r;
  ctl_t          ctl_r;
  logic [DW:0]   den_r, remm_r, remp_r;
  logic [XW-1:0] xm_r, xp_r, qm_r, qp_r;

  always_comb begin
    dd  = {1'b0, den_in};
    shm = {remm_in, xm_in[XW-1]};
    shp = {remp_in, xp_in[XW-1]};
    tm  = (shm >= dd);
    tp  = (shp >= dd);
    rm_nxt = tm ? (shm - dd) : shm;
    rp_nxt = tp ? (shp - dd) : shp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
    if (en) begin
      ctl_r  <= ctl_in;
      den_r  <= den_in;
      xm_r   <= {xm_in[XW-2:0], 1'b0};
      xp_r   <= {xp_in[XW-2:0], 1'b0};
      remm_r <= rm_nxt[DW:0];
      remp_r <= rp_nxt[DW:0];
      qm_r   <= {qm_in[XW-2:0], tm};
      qp_r   <= {qp_in[XW-2:0], tp};
    end
  end

  assign v_out    = v_r;
  assign ctl_out  = ctl_r;
  assign den_out  = den_r;
  assign xm_out   = xm_r;
  assign xp_out   = xp_r;
  assign remm_out = remm_r;
  assign remp_out = remp_r;
  assign qm_out   = qm_r;
  assign qp_out   = qp_r;
endmodule
`default_nettype wire

>>> hdl/quadratic_root_solver.sv
// quadratic root solver: top level with product, discriminant, root and divide chains
//
// Input stream: one coefficient set a, b, c (signed, FRAC_BITS fraction bits) per transfer.
// Output stream: root_minus and root_plus in tdata, status and saturated flag in tuser.
// Status 0 roots valid, 1 complex (roots zero), 2 no solution (a = b = 0, c nonzero).
// A linear set (a = 0) gives -c/b in both roots; out-of-range roots clip and set
// the saturated flag.
// The pipeline has DATA_WIDTH + 1 square root cells, DATA_WIDTH + 2 + FRAC_BITS divider
// cells and four further registers.
// Throughput is one set per cycle while the output is not stalled: every cell of
// both chains hands its partial result to the next cell each cycle.
// A stalled receiver freezes the whole chain; the input is then not ready, so
// no transfer is lost. Reset empties the chain and drops out_tvalid.
`default_nettype none
module quadratic_root_solver #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IN_TW  = ((3*DATA_WIDTH+7)/8)*8,
  localparam int OUT_TW = ((2*DATA_WIDTH+7)/8)*8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,   // coef_a, coef_b, coef_c
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_TW-1:0]      out_tdata,  // root_minus, root_plus
  output logic [2:0]             out_tuser   // status, saturated
);
  import qrs_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int RW   = DW + 1;
  localparam int NUMW = DW + 3;
  localparam int MW   = DW + 2;
  localparam int XW   = MW + FRAC_BITS;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // products
  logic signed [DW-1:0] ia, ib, ic;
  logic [DW-1:0]        ma, mb, mc;
  assign ia = in_tdata[DW-1:0];
  assign ib = in_tdata[2*DW-1:DW];
  assign ic = in_tdata[3*DW-1:2*DW];
  assign ma = ia[DW-1] ? (~ia + 1'b1) : ia;
  assign mb = ib[DW-1] ? (~ib + 1'b1) : ib;
  assign mc = ic[DW-1] ? (~ic + 1'b1) : ic;

  logic                 v1_r;
  logic [2*DW-1:0]      bb_r, ac_r;
  logic                 acneg_r;
  logic signed [DW-1:0] a1_r, b1_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
    if (en) begin
      bb_r    <= mb * mb;
      ac_r    <= ma * mc;
      acneg_r <= ia[DW-1] ^ ic[DW-1];
      a1_r    <= ia;
      b1_r    <= ib;
      c1_r    <= ic;
    end
  end

  // discriminant and case selection
  logic [2*RW-1:0] bbx, ac4, disc_nxt;
  ctl_t            ctl1;
  always_comb begin
    bbx = {2'b00, bb_r};
    ac4 = {ac_r, 2'b00};
    disc_nxt = '0;
    ctl1 = '{kind: K_ROOTS, lin: (a1_r == '0), neg_m: 1'b0, neg_p: 1'b0};
    if (acneg_r) begin
      disc_nxt = bbx + ac4;
    end else if (ac4 > bbx) begin
      ctl1.kind = K_CPLX;
    end else begin
      disc_nxt = bbx - ac4;
    end
    if (ctl1.kind != K_CPLX && a1_r == '0 && b1_r == '0) begin
      ctl1.kind = (c1_r != '0) ? K_NOSOL : K_ZERO;
    end
  end

  logic            v2_r;
  ctl_t            ctl2_r;
  logic [2*RW-1:0] disc_r;
  logic [DW-1:0]   a2_r, b2_r, c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      ctl2_r <= ctl1;
      disc_r <= disc_nxt;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
    end
  end

  // square root chain
  logic            sq_v   [0:RW];
  ctl_t            sq_ctl [0:RW];
  logic [2*RW-1:0] sq_d   [0:RW];
  logic [RW:0]     sq_rem [0:RW];
  logic [RW-1:0]   sq_root[0:RW];
  logic [DW-1:0]   sq_a   [0:RW];
  logic [DW-1:0]   sq_b   [0:RW];
  logic [DW-1:0]   sq_c   [0:RW];

  assign sq_v[0]    = v2_r;
  assign sq_ctl[0]  = ctl2_r;
  assign sq_d[0]    = disc_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_a[0]    = a2_r;
  assign sq_b[0]    = b2_r;
  assign sq_c[0]    = c2_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.DW(DW), .RW(RW), .STEP(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (sq_v[k]),
      .ctl_in  (sq_ctl[k]),
      .d_in    (sq_d[k]),
      .rem_in  (sq_rem[k]),
      .root_in (sq_root[k]),
      .a_in    (sq_a[k]),
      .b_in    (sq_b[k]),
      .c_in    (sq_c[k]),
      .v_out   (sq_v[k+1]),
      .ctl_out (sq_ctl[k+1]),
      .d_out   (sq_d[k+1]),
      .rem_out (sq_rem[k+1]),
      .root_out(sq_root[k+1]),
      .a_out   (sq_a[k+1]),
      .b_out   (sq_b[k+1]),
      .c_out   (sq_c[k+1])
    );
  end

  // numerators and divisor
  logic signed [NUMW-1:0] nb, ss, nm, np, nc;
  logic signed [DW:0]     den;
  logic [MW-1:0]          mag_m, mag_p;
  logic [DW:0]            mag_d;
  ctl_t                   ctl3;
  always_comb begin
    nb  = -{{3{sq_b[RW][DW-1]}}, sq_b[RW]};
    nc  = -{{3{sq_c[RW][DW-1]}}, sq_c[RW]};
    ss  = {2'b00, sq_root[RW]};
    ctl3 = sq_ctl[RW];
    if (ctl3.lin) begin
      nm  = nc;
      np  = nc;
      den = {sq_b[RW][DW-1], sq_b[RW]};
    end else begin
      nm  = nb - ss;
      np  = nb + ss;
      den = {sq_a[RW], 1'b0};
    end
    mag_m = nm[NUMW-1] ? MW'(-nm) : nm[MW-1:0];
    mag_p = np[NUMW-1] ? MW'(-np) : np[MW-1:0];
    mag_d = den[DW] ? (~den + 1'b1) : den;
    ctl3.neg_m = nm[NUMW-1] ^ den[DW];
    ctl3.neg_p = np[NUMW-1] ^ den[DW];
  end

  logic          v3_r;
  ctl_t          ctl3_r;
  logic [DW:0]   den3_r;
  logic [XW-1:0] xm3_r, xp3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sq_v[RW];
    end
    if (en) begin
      ctl3_r <= ctl3;
      den3_r <= mag_d;
      xm3_r  <= {mag_m, {FRAC_BITS{1'b0}}};
      xp3_r  <= {mag_p, {FRAC_BITS{1'b0}}};
    end
  end

  // divider chain
  logic          dv_v   [0:XW];
  ctl_t          dv_ctl [0:XW];
  logic [DW:0]   dv_den [0:XW];
  logic [XW-1:0] dv_xm  [0:XW];
  logic [XW-1:0] dv_xp  [0:XW];
  logic [DW:0]   dv_rm  [0:XW];
  logic [DW:0]   dv_rp  [0:XW];
  logic [XW-1:0] dv_qm  [0:XW];
  logic [XW-1:0] dv_qp  [0:XW];

  assign dv_v[0]   = v3_r;
  assign dv_ctl[0] = ctl3_r;
  assign dv_den[0] = den3_r;
  assign dv_xm[0]  = xm3_r;
  assign dv_xp[0]  = xp3_r;
  assign dv_rm[0]  = '0;
  assign dv_rp[0]  = '0;
  assign dv_qm[0]  = '0;
  assign dv_qp[0]  = '0;

  for (genvar k = 0; k < XW; k++) begin : g_div
    qrs_div_cell #(.DW(DW), .XW(XW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (dv_v[k]),
      .ctl_in  (dv_ctl[k]),
      .den_in  (dv_den[k]),
      .xm_in   (dv_xm[k]),
      .xp_in   (dv_xp[k]),
      .remm_in (dv_rm[k]),
      .remp_in (dv_rp[k]),
      .qm_in   (dv_qm[k]),
      .qp_in   (dv_qp[k]),
      .v_out   (dv_v[k+1]),
      .ctl_out (dv_ctl[k+1]),
      .den_out (dv_den[k+1]),
      .xm_out  (dv_xm[k+1]),
      .xp_out  (dv_xp[k+1]),
      .remm_out(dv_rm[k+1]),
      .remp_out(dv_rp[k+1]),
      .qm_out  (dv_qm[k+1]),
      .qp_out  (dv_qp[k+1])
    );
  end

  // saturation, sign and result selection
  localparam logic [XW-1:0] LIM_POS = XW'((64'd1 << (DW-1)) - 64'd1);
  localparam logic [XW-1:0] LIM_NEG = XW'(64'd1 << (DW-1));

  ctl_t          ctl4;
  logic [XW-1:0] lim_m, lim_p, qm_c, qp_c, qm, qp;
  logic          sat_m, sat_p;
  logic [DW-1:0] rm_nxt, rp_nxt;
  logic [1:0]    st_nxt;
  logic          sat_nxt;
  always_comb begin
    ctl4  = dv_ctl[XW];
    qm    = dv_qm[XW];
    qp    = dv_qp[XW];
    lim_m = ctl4.neg_m ? LIM_NEG : LIM_POS;
    lim_p = ctl4.neg_p ? LIM_NEG : LIM_POS;
    sat_m = (qm > lim_m);
    sat_p = (qp > lim_p);
    qm_c  = sat_m ? lim_m : qm;
    qp_c  = sat_p ? lim_p : qp;
    rm_nxt  = '0;
    rp_nxt  = '0;
    sat_nxt = 1'b0;
    case (ctl4.kind)
      K_ROOTS: begin
        st_nxt  = ST_OK;
        rm_nxt  = ctl4.neg_m ? DW'(-qm_c) : qm_c[DW-1:0];
        rp_nxt  = ctl4.neg_p ? DW'(-qp_c) : qp_c[DW-1:0];
        sat_nxt = sat_m | sat_p;
      end
      K_CPLX:  st_nxt = ST_CPLX;
      K_NOSOL: st_nxt = ST_NOSOL;
      default: st_nxt = ST_OK;
    endcase
  end

  logic          ov_r;
  logic [DW-1:0] rm_r, rp_r;
  logic [1:0]    st_r;
  logic          sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= dv_v[XW];
    end
    if (en) begin
      rm_r  <= rm_nxt;
      rp_r  <= rp_nxt;
      st_r  <= st_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_TW'({rp_r, rm_r});
  assign out_tuser  = {sat_r, st_r};
endmodule
`default_nettype wire

>>> hdl/qrs_checker.sv
// port checker for the quadratic root solver, bound to the top level
`default_nettype none
module qrs_checker #(
  parameter int DATA_WIDTH = 32,
  localparam int IN_TW  = ((3*DATA_WIDTH+7)/8)*8,
  localparam int OUT_TW = ((2*DATA_WIDTH+7)/8)*8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [IN_TW-1:0]  in_tdata,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_TW-1:0] out_tdata,
  input wire logic [2:0]        out_tuser
);
  import qrs_pkg::*;

  logic [2*DATA_WIDTH-1:0] roots;
  assign roots = out_tdata[2*DATA_WIDTH-1:0];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == ST_OK || out_tuser[1:0] == ST_CPLX
                    || out_tuser[1:0] == ST_NOSOL))
    else $error("unused status code");

  a_noroot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_CPLX || out_tuser[1:0] == ST_NOSOL)
    |-> roots == '0 && !out_tuser[2])
    else $error("roots not cleared without real solution");

  a_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> in_tdata == in_tdata)
    else $error("input transfer unknown");
endmodule

bind quadratic_root_solver qrs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
